/* src/ldr_pkg.sv */
`timescale 1ns / 1ps

package ldr_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DX,
        ST_DY,
        ST_ABSX,
        ST_ABSY,
        ST_MAJ,
        ST_DIV,
        ST_ADV_X,
        ST_ADV_Y
    } ldr_state_t;

    typedef enum logic {
        ACT_LOAD = 1'b0,
        ACT_STEP = 1'b1
    } ldr_action_t;

endpackage

/* src/ldr_au.sv */
`timescale 1ns / 1ps

// Shared add/subtract unit. On subtract, borrow is high when a < b (unsigned).
module ldr_au #(
    parameter int WIDTH = 26
) (
    input  logic [WIDTH-1:0] a,
    input  logic [WIDTH-1:0] b,
    input  logic             sub,
    output logic [WIDTH-1:0] result,
    output logic             borrow
);

    logic [WIDTH:0] sum;

    always_comb
    begin
        sum    = {1'b0, a} + {1'b0, (sub ? ~b : b)} + {{WIDTH{1'b0}}, sub};
        result = sum[WIDTH-1:0];
        borrow = sub & ~sum[WIDTH];
    end

endmodule

/* src/line_dda_rasterizer_core.sv */
`timescale 1ns / 1ps

// Load transfer: busy through ST_DX, ST_DY, ST_ABSX, ST_ABSY, ST_MAJ and the divider in ST_DIV,
// which runs in the shared adder. Pixel transfer: result registered on acceptance, then the
// x and y accumulators are advanced one after the other through the same adder (ST_ADV_X,
// ST_ADV_Y); the last pixel of a line needs no advance and leaves the block in ST_IDLE.
// Step transfer with no active line: result registered on acceptance, block stays in ST_IDLE.
// rst_n is asynchronous, active low, and clears the sequencer, the line state and output valid.
module line_dda_rasterizer_core
    import ldr_pkg::*;
#(
    parameter int COORD_BITS = 10,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      s_axis_tvalid,
    output logic                                      s_axis_tready,
    // start_x, start_y, end_x, end_y from the lowest bit up, zero padded
    input  logic [((4*COORD_BITS+7)/8)*8-1:0]         s_axis_tdata,
    // action
    input  logic                                      s_axis_tuser,
    output logic                                      m_axis_tvalid,
    input  logic                                      m_axis_tready,
    // pixel_x, pixel_y from the lowest bit up, zero padded
    output logic [((2*COORD_BITS+7)/8)*8-1:0]         m_axis_tdata,
    // valid_res
    output logic                                      m_axis_tuser,
    output logic                                      m_axis_tlast
);

    localparam int C     = COORD_BITS;
    localparam int F     = FRAC_BITS;
    localparam int W     = C + F;
    localparam int OUT_W = ((2*COORD_BITS+7)/8)*8;
    localparam int CNT_W = $clog2(FRAC_BITS + 1);
    localparam logic [W-1:0] ONE_FX = {{(C-1){1'b0}}, 1'b1, {F{1'b0}}};

    ldr_state_t state_reg, state_next;

    logic [C-1:0]   sx_reg, sx_next, sy_reg, sy_next;
    logic [C-1:0]   ex_reg, ex_next, ey_reg, ey_next;
    logic [C-1:0]   ax_reg, ax_next, ay_reg, ay_next;
    logic [C-1:0]   major_reg, major_next;
    logic [C:0]     rem_reg, rem_next;
    logic [F:0]     quo_reg, quo_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [W-1:0]   xpos_reg, xpos_next, ypos_reg, ypos_next;
    logic [F:0]     step_reg, step_next;
    logic [C:0]     left_reg, left_next;
    logic           active_reg, active_next;
    logic           xmaj_reg, xmaj_next;
    logic           xdesc_reg, xdesc_next;
    logic           ydesc_reg, ydesc_next;

    logic [C-1:0]   out_x_reg, out_x_next, out_y_reg, out_y_next;
    logic           out_user_reg, out_user_next;
    logic           out_last_reg, out_last_next;
    logic           out_valid_reg, out_valid_next;

    logic [W-1:0]   au_a, au_b, au_res;
    logic           au_sub, au_borrow;
    logic           in_fire;
    logic           in_step;
    logic           div_ge;
    logic [C:0]     rem_after;
    logic [F:0]     quo_shift;
    logic [W-1:0]   step_ext;

    ldr_au #(
        .WIDTH (W)
    ) u_au (
        .a      (au_a),
        .b      (au_b),
        .sub    (au_sub),
        .result (au_res),
        .borrow (au_borrow)
    );

    assign s_axis_tready = (state_reg == ST_IDLE) && (!out_valid_reg || m_axis_tready);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign in_step       = (s_axis_tuser == ACT_STEP);
    assign step_ext      = {{(C-1){1'b0}}, step_reg};

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_W'({out_y_reg, out_x_reg});
    assign m_axis_tuser  = out_user_reg;
    assign m_axis_tlast  = out_last_reg;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (!in_step)
                        state_next = ST_DX;
                    else if (active_reg && (left_reg != '0))
                        state_next = ST_ADV_X;
                end
            end
            ST_DX:    state_next = ST_DY;
            ST_DY:    state_next = ST_ABSX;
            ST_ABSX:  state_next = ST_ABSY;
            ST_ABSY:  state_next = ST_MAJ;
            ST_MAJ:   state_next = ST_DIV;
            ST_DIV:
            begin
                if (cnt_reg == '0)
                    state_next = ST_IDLE;
            end
            ST_ADV_X: state_next = ST_ADV_Y;
            ST_ADV_Y: state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Datapath control and register updates.
    always_comb
    begin
        sx_next        = sx_reg;
        sy_next        = sy_reg;
        ex_next        = ex_reg;
        ey_next        = ey_reg;
        ax_next        = ax_reg;
        ay_next        = ay_reg;
        major_next     = major_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        cnt_next       = cnt_reg;
        xpos_next      = xpos_reg;
        ypos_next      = ypos_reg;
        step_next      = step_reg;
        left_next      = left_reg;
        active_next    = active_reg;
        xmaj_next      = xmaj_reg;
        xdesc_next     = xdesc_reg;
        ydesc_next     = ydesc_reg;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_user_next  = out_user_reg;
        out_last_next  = out_last_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        au_a           = '0;
        au_b           = '0;
        au_sub         = 1'b1;

        // Divider step: compare the partial remainder against the major span.
        div_ge    = 1'b0;
        rem_after = rem_reg;
        quo_shift = {quo_reg[F-1:0], 1'b0};

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (!in_step)
                    begin
                        sx_next     = s_axis_tdata[C-1:0];
                        sy_next     = s_axis_tdata[2*C-1:C];
                        ex_next     = s_axis_tdata[3*C-1:2*C];
                        ey_next     = s_axis_tdata[4*C-1:3*C];
                        xpos_next   = {s_axis_tdata[C-1:0], {F{1'b0}}};
                        ypos_next   = {s_axis_tdata[2*C-1:C], {F{1'b0}}};
                        active_next = 1'b0;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        out_user_next  = active_reg;
                        out_x_next     = active_reg ? xpos_reg[W-1:F] : '0;
                        out_y_next     = active_reg ? ypos_reg[W-1:F] : '0;
                        out_last_next  = active_reg && (left_reg == '0);
                        if (active_reg && (left_reg == '0))
                            active_next = 1'b0;
                    end
                end
            end
            ST_DX:
            begin
                au_a       = {{F{1'b0}}, ex_reg};
                au_b       = {{F{1'b0}}, sx_reg};
                ax_next    = au_res[C-1:0];
                xdesc_next = au_borrow;
            end
            ST_DY:
            begin
                au_a       = {{F{1'b0}}, ey_reg};
                au_b       = {{F{1'b0}}, sy_reg};
                ay_next    = au_res[C-1:0];
                ydesc_next = au_borrow;
            end
            ST_ABSX:
            begin
                au_b = {{F{1'b0}}, ax_reg};
                if (xdesc_reg)
                    ax_next = au_res[C-1:0];
            end
            ST_ABSY:
            begin
                au_b = {{F{1'b0}}, ay_reg};
                if (ydesc_reg)
                    ay_next = au_res[C-1:0];
            end
            ST_MAJ:
            begin
                // A borrow means |dy| < |dx|, so x is the major axis.
                au_a       = {{F{1'b0}}, ay_reg};
                au_b       = {{F{1'b0}}, ax_reg};
                xmaj_next  = au_borrow;
                major_next = au_borrow ? ax_reg : ay_reg;
                rem_next   = {1'b0, (au_borrow ? ay_reg : ax_reg)};
                left_next  = {1'b0, (au_borrow ? ax_reg : ay_reg)};
                quo_next   = '0;
                cnt_next   = CNT_W'(F);
            end
            ST_DIV:
            begin
                au_a      = {{(F-1){1'b0}}, rem_reg};
                au_b      = {{F{1'b0}}, major_reg};
                div_ge    = !au_borrow;
                rem_after = div_ge ? au_res[C:0] : rem_reg;
                quo_shift = {quo_reg[F-1:0], div_ge};
                quo_next  = quo_shift;
                rem_next  = {rem_after[C-1:0], 1'b0};
                if (cnt_reg == '0)
                begin
                    step_next   = (major_reg == '0) ? '0 : quo_shift;
                    active_next = 1'b1;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_ADV_X:
            begin
                au_a      = xpos_reg;
                au_b      = xmaj_reg ? ONE_FX : step_ext;
                au_sub    = xdesc_reg;
                xpos_next = au_res;
            end
            ST_ADV_Y:
            begin
                au_a      = ypos_reg;
                au_b      = xmaj_reg ? step_ext : ONE_FX;
                au_sub    = ydesc_reg;
                ypos_next = au_res;
                left_next = left_reg - 1'b1;
            end
            default:
            begin
                au_sub = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            xpos_reg      <= '0;
            ypos_reg      <= '0;
            step_reg      <= '0;
            left_reg      <= '0;
            active_reg    <= 1'b0;
            xmaj_reg      <= 1'b0;
            xdesc_reg     <= 1'b0;
            ydesc_reg     <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            xpos_reg      <= xpos_next;
            ypos_reg      <= ypos_next;
            step_reg      <= step_next;
            left_reg      <= left_next;
            active_reg    <= active_next;
            xmaj_reg      <= xmaj_next;
            xdesc_reg     <= xdesc_next;
            ydesc_reg     <= ydesc_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sx_reg       <= sx_next;
        sy_reg       <= sy_next;
        ex_reg       <= ex_next;
        ey_reg       <= ey_next;
        ax_reg       <= ax_next;
        ay_reg       <= ay_next;
        major_reg    <= major_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        out_x_reg    <= out_x_next;
        out_y_reg    <= out_y_next;
        out_user_reg <= out_user_next;
        out_last_reg <= out_last_next;
    end

endmodule

/* verif/line_dda_rasterizer_checker.sv */
`timescale 1ns / 1ps

module line_dda_rasterizer_checker
    import ldr_pkg::*;
#(
    parameter int COORD_BITS = 10,
    parameter int FRAC_BITS  = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    input  logic                              s_axis_tready,
    // start_x, start_y, end_x, end_y from the lowest bit up, zero padded
    input  logic [((4*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
    // action
    input  logic                              s_axis_tuser,
    input  logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // pixel_x, pixel_y from the lowest bit up, zero padded
    input  logic [((2*COORD_BITS+7)/8)*8-1:0] m_axis_tdata,
    // valid_res
    input  logic                              m_axis_tuser,
    input  logic                              m_axis_tlast,
    output int                                fail_count,
    output int                                pixels_due
);

    localparam int POS_BITS   = COORD_BITS + FRAC_BITS;
    localparam int SLOPE_BITS = FRAC_BITS + 1;
    localparam int COUNT_BITS = COORD_BITS + 1;
    localparam logic [POS_BITS-1:0] UNIT_STEP = POS_BITS'(1) << FRAC_BITS;

    typedef struct packed {
        logic [COORD_BITS-1:0] px;
        logic [COORD_BITS-1:0] py;
        logic                  emitted;
        logic                  is_last;
    } pixel_t;

    logic [POS_BITS-1:0]   x_acc;
    logic [POS_BITS-1:0]   y_acc;
    logic [SLOPE_BITS-1:0] slope;
    logic [COUNT_BITS-1:0] steps_to_go;
    bit                    drawing;
    bit                    x_major;
    bit                    x_down;
    bit                    y_down;
    pixel_t                pixel_queue[$];

    initial
    begin
        fail_count = 0;
        pixels_due = 0;
    end

    function automatic void report_failure(input string msg);
        fail_count++;
        if (fail_count <= 10)
        begin
            $display("%0t ns: %s", $time, msg);
        end
    endfunction

    // Advances the line state by one accepted transfer and, for a step, queues the pixel it will return.
    task automatic rasterize(input ldr_action_t act,
                             input logic [((4*COORD_BITS+7)/8)*8-1:0] data);
        logic [COORD_BITS-1:0] sx;
        logic [COORD_BITS-1:0] sy;
        logic [COORD_BITS-1:0] ex;
        logic [COORD_BITS-1:0] ey;
        logic [COORD_BITS-1:0] adx;
        logic [COORD_BITS-1:0] ady;
        logic [COORD_BITS-1:0] major;
        logic [COORD_BITS-1:0] minor;
        logic [POS_BITS-1:0]   scaled;
        pixel_t                pix;
        sx = data[COORD_BITS-1:0];
        sy = data[2*COORD_BITS-1:COORD_BITS];
        ex = data[3*COORD_BITS-1:2*COORD_BITS];
        ey = data[4*COORD_BITS-1:3*COORD_BITS];
        if (act == ACT_LOAD)
        begin
            x_down      = ex < sx;
            y_down      = ey < sy;
            adx         = x_down ? sx - ex : ex - sx;
            ady         = y_down ? sy - ey : ey - sy;
            x_major     = ady < adx;
            major       = x_major ? adx : ady;
            minor       = x_major ? ady : adx;
            scaled      = POS_BITS'(minor) << FRAC_BITS;
            slope       = (major == '0) ? '0 : SLOPE_BITS'(scaled / POS_BITS'(major));
            x_acc       = POS_BITS'(sx) << FRAC_BITS;
            y_acc       = POS_BITS'(sy) << FRAC_BITS;
            steps_to_go = COUNT_BITS'(major);
            drawing     = 1'b1;
        end
        else if (!drawing)
        begin
            pixel_queue.push_back('0);
        end
        else
        begin
            pix.px      = x_acc[POS_BITS-1:FRAC_BITS];
            pix.py      = y_acc[POS_BITS-1:FRAC_BITS];
            pix.emitted = 1'b1;
            pix.is_last = steps_to_go == '0;
            pixel_queue.push_back(pix);
            if (pix.is_last)
            begin
                drawing = 1'b0;
            end
            else
            begin
                // The major axis moves a whole pixel, the minor one by the fractional slope.
                if (x_major)
                begin
                    x_acc = x_down ? x_acc - UNIT_STEP : x_acc + UNIT_STEP;
                    y_acc = y_down ? y_acc - POS_BITS'(slope) : y_acc + POS_BITS'(slope);
                end
                else
                begin
                    y_acc = y_down ? y_acc - UNIT_STEP : y_acc + UNIT_STEP;
                    x_acc = x_down ? x_acc - POS_BITS'(slope) : x_acc + POS_BITS'(slope);
                end
                steps_to_go--;
            end
        end
    endtask

    always @(posedge clk)
    begin
        pixel_t got;
        pixel_t want;
        if (!rst_n)
        begin
            x_acc       = '0;
            y_acc       = '0;
            slope       = '0;
            steps_to_go = '0;
            drawing     = 1'b0;
            x_major     = 1'b0;
            x_down      = 1'b0;
            y_down      = 1'b0;
            pixel_queue.delete();
        end
        else
        begin
            // A result never stems from an input accepted at the same edge, so check first.
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.px      = m_axis_tdata[COORD_BITS-1:0];
                got.py      = m_axis_tdata[2*COORD_BITS-1:COORD_BITS];
                got.emitted = m_axis_tuser;
                got.is_last = m_axis_tlast;
                if (pixel_queue.size() == 0)
                begin
                    report_failure($sformatf("unexpected pixel x=%0d y=%0d valid=%0b last=%0b",
                                             got.px, got.py, got.emitted, got.is_last));
                end
                else
                begin
                    want = pixel_queue.pop_front();
                    if (got !== want)
                    begin
                        report_failure($sformatf({"pixel mismatch: expected x=%0d y=%0d ",
                                                  "valid=%0b last=%0b, got x=%0d y=%0d ",
                                                  "valid=%0b last=%0b"},
                                                 want.px, want.py, want.emitted, want.is_last,
                                                 got.px, got.py, got.emitted, got.is_last));
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                rasterize(ldr_action_t'(s_axis_tuser), s_axis_tdata);
            end
        end
        pixels_due = pixel_queue.size();
    end

endmodule

/* verif/tb_line_dda_rasterizer_core.sv */
`timescale 1ns / 1ps

module tb_line_dda_rasterizer_core;
    import ldr_pkg::*;

    localparam int COORD_BITS = 10;
    localparam int FRAC_BITS  = 16;
    localparam int S_W        = ((4*COORD_BITS+7)/8)*8;
    localparam int M_W        = ((2*COORD_BITS+7)/8)*8;
    localparam int RUN_ITEMS  = 1150;
    localparam int MAX_COORD  = (1 << COORD_BITS) - 1;

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           s_axis_tvalid = 1'b0;
    logic           s_axis_tready;
    logic [S_W-1:0] s_axis_tdata = '0;
    logic           s_axis_tuser = 1'b0;
    logic           m_axis_tvalid;
    logic           m_axis_tready = 1'b0;
    logic [M_W-1:0] m_axis_tdata;
    logic           m_axis_tuser;
    logic           m_axis_tlast;

    int fail_count;
    int pixels_due;
    int items_sent = 0;
    int results_seen = 0;
    int send_gap_odds = 0;
    bit tail_phase = 1'b0;

    always #1 clk = ~clk;

    line_dda_rasterizer_core #(
        .COORD_BITS(COORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    line_dda_rasterizer_checker #(
        .COORD_BITS(COORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_pixel_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast),
        .fail_count   (fail_count),
        .pixels_due   (pixels_due)
    );

    always @(posedge clk)
    begin
        if (m_axis_tvalid && m_axis_tready)
        begin
            results_seen++;
        end
    end

    // Pixel sink: random stall bursts, one long hold-off so that the block backs up into
    // its input, and no stalls at all in the tail of the run.
    initial
    begin : pixel_sink
        int idle_left;
        int idle_odds;
        bit long_hold_done;
        idle_left      = 0;
        idle_odds      = 4;
        long_hold_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if ($urandom_range(0, 63) == 0)
            begin
                idle_odds = $urandom_range(0, 6);
            end
            if (tail_phase)
            begin
                idle_left = 0;
            end
            else if (idle_left == 0)
            begin
                if (!long_hold_done && results_seen >= 60)
                begin
                    long_hold_done = 1'b1;
                    idle_left      = 400;
                end
                else if (idle_odds != 0 && $urandom_range(1, idle_odds + 2) == 1)
                begin
                    idle_left = $urandom_range(1, 10);
                end
            end
            if (idle_left > 0)
            begin
                m_axis_tready <= 1'b0;
                idle_left--;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Called at a rising edge; returns at the edge where the transfer is accepted.
    task automatic send_item(input ldr_action_t act, input logic [COORD_BITS-1:0] sx,
                             input logic [COORD_BITS-1:0] sy, input logic [COORD_BITS-1:0] ex,
                             input logic [COORD_BITS-1:0] ey);
        int gap;
        gap = 0;
        if (!tail_phase && send_gap_odds != 0 && $urandom_range(1, send_gap_odds) == 1)
        begin
            gap = $urandom_range(1, 10);
        end
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= S_W'({ey, ex, sy, sx});
        do @(posedge clk); while (!s_axis_tready);
        items_sent++;
    endtask

    // Pixel requests carry random data, which the block must ignore.
    task automatic pull_pixels(input int count);
        repeat (count)
        begin
            send_item(ACT_STEP, COORD_BITS'($urandom), COORD_BITS'($urandom),
                      COORD_BITS'($urandom), COORD_BITS'($urandom));
        end
    endtask

    task automatic draw_line(input logic [COORD_BITS-1:0] sx, input logic [COORD_BITS-1:0] sy,
                             input logic [COORD_BITS-1:0] ex, input logic [COORD_BITS-1:0] ey,
                             input int pulls);
        send_item(ACT_LOAD, sx, sy, ex, ey);
        pull_pixels(pulls);
    endtask

    function automatic int pixel_count(input int sx, input int sy, input int ex, input int ey);
        int adx;
        int ady;
        adx = (sx > ex) ? sx - ex : ex - sx;
        ady = (sy > ey) ? sy - ey : ey - sy;
        return ((adx > ady) ? adx : ady) + 1;
    endfunction

    // Endpoints land on the border of the coordinate range now and then.
    function automatic logic [COORD_BITS-1:0] rand_coord();
        if ($urandom_range(0, 7) == 0)
        begin
            return ($urandom_range(0, 1) == 1) ? COORD_BITS'(MAX_COORD) : '0;
        end
        return COORD_BITS'($urandom_range(0, MAX_COORD));
    endfunction

    function automatic logic [COORD_BITS-1:0] near_coord(input int base, input int span);
        int offset;
        int coord;
        offset = $urandom_range(0, span);
        coord  = ($urandom_range(0, 1) == 1) ? base + offset : base - offset;
        if (coord > MAX_COORD)
        begin
            coord = base - offset;
        end
        if (coord < 0)
        begin
            coord = base + offset;
        end
        return COORD_BITS'(coord);
    endfunction

    initial
    begin : line_source
        logic [COORD_BITS-1:0] sx;
        logic [COORD_BITS-1:0] sy;
        logic [COORD_BITS-1:0] ex;
        logic [COORD_BITS-1:0] ey;
        int n;
        int span;
        int pick;
        int pulls;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Request before any line, then a single point followed by one request too many.
        pull_pixels(1);
        draw_line(0, 0, 0, 0, 2);
        // Horizontal right to left at the top corner, then a vertical line going down.
        draw_line(1023, 1023, 1021, 1023, 3);
        draw_line(5, 1023, 5, 1021, 3);
        // Diagonal with a full unit slope.
        draw_line(0, 0, 2, 2, 3);
        // Shallow line cut short by the next load, then a steep one and an extra request.
        draw_line(1023, 0, 1020, 2, 2);
        draw_line(0, 1023, 2, 1020, 5);

        send_gap_odds = 4;
        sx = COORD_BITS'($urandom_range(0, 60));
        ex = COORD_BITS'(int'(sx) + $urandom_range(350, 450));
        sy = COORD_BITS'($urandom_range(300, 700));
        ey = COORD_BITS'($urandom_range(300, 700));
        draw_line(sx, sy, ex, ey, pixel_count(int'(sx), int'(sy), int'(ex), int'(ey)));

        while (items_sent < RUN_ITEMS)
        begin
            tail_phase = items_sent >= RUN_ITEMS - 150;
            if ($urandom_range(0, 7) == 0)
            begin
                send_gap_odds = $urandom_range(0, 6);
            end
            pick = $urandom_range(0, 99);
            if (pick < 5)
            begin
                pull_pixels($urandom_range(1, 3));
            end
            else if (pick < 12)
            begin
                // Arbitrary endpoints across the whole range, usually abandoned early.
                draw_line(COORD_BITS'($urandom), COORD_BITS'($urandom), COORD_BITS'($urandom),
                          COORD_BITS'($urandom), $urandom_range(0, 24));
            end
            else
            begin
                span = (pick < 90) ? 12 : (pick < 98) ? 60 : 250;
                sx   = rand_coord();
                sy   = rand_coord();
                ex   = near_coord(int'(sx), span);
                ey   = near_coord(int'(sy), span);
                n    = pixel_count(int'(sx), int'(sy), int'(ex), int'(ey));
                pulls = $urandom_range(0, 19);
                if (pulls < 17)
                begin
                    pulls = n;
                end
                else if (pulls < 19)
                begin
                    pulls = n + $urandom_range(1, 2);
                end
                else
                begin
                    pulls = $urandom_range(0, n - 1);
                end
                draw_line(sx, sy, ex, ey, pulls);
            end
        end
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        wait (pixels_due == 0);
        repeat (40) @(posedge clk);
        if (fail_count == 0 && pixels_due == 0)
        begin
            $display("** line_dda_rasterizer_core: PASSED **");
        end
        else
        begin
            $display("** line_dda_rasterizer_core: FAILED **");
        end
        $finish;
    end

    initial
    begin : watchdog
        #2000000;
        $display("** line_dda_rasterizer_core: FAILED **");
        $finish;
    end

endmodule
